[rtl/toti_pkg.sv]
// ----------------------------------------------------------------------------
// Two-opt tour improver package
// Shared constants, payload types and the controller/datapath command set.
// ----------------------------------------------------------------------------
package toti_pkg;

    localparam int MAX_CITIES_DEF = 128;
    localparam int DIST_BITS_DEF  = 16;
    localparam int LEN_W          = 23;
    localparam logic [LEN_W-1:0] LEN_MAX = {LEN_W{1'b1}};

    // item opcodes
    localparam logic [2:0] OP_LOAD_DIST = 3'd0;
    localparam logic [2:0] OP_LOAD_POS  = 3'd1;
    localparam logic [2:0] OP_RECOMPUTE = 3'd2;
    localparam logic [2:0] OP_TRIAL     = 3'd3;
    localparam logic [2:0] OP_READ_POS  = 3'd4;

    // configuration register indexes
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_CITIES  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FIRST   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MARGIN  = 2'd2;
    localparam int CFG_DATA_W = 16;

    localparam logic [7:0]  CITIES_RST = 8'd127;
    localparam logic [6:0]  FIRST_RST  = 7'd1;
    localparam logic [15:0] MARGIN_RST = 16'd100;

    typedef struct packed {
        logic [2:0]  opcode;
        logic [6:0]  city_from;
        logic [6:0]  city_to;
        logic [15:0] distance_value;
        logic [7:0]  position;
        logic [6:0]  city_id;
        logic [6:0]  first_start;
        logic [6:0]  first_end;
        logic [6:0]  second_start;
        logic [6:0]  second_end;
    } item_t;

    typedef struct packed {
        logic [LEN_W-1:0] tour_length;
        logic             accepted;
        logic [6:0]       city_out;
        logic             status;
    } result_t;

    typedef enum logic [2:0] {TA_POS, TA_I, TA_IM1, TA_IP1, TA_J, TA_JP1} tour_ra_t;
    typedef enum logic [1:0] {TW_NONE, TW_POS, TW_I, TW_J} tour_wr_t;
    typedef enum logic [2:0] {CP_NONE, CP_A, CP_B, CP_C, CP_D, CP_T, CP_SHIFT} cap_t;
    typedef enum logic [2:0] {DO_NONE, DO_WRITE, DO_AC, DO_BD, DO_AB, DO_CD} dist_op_t;
    typedef enum logic [2:0] {AO_NONE, AO_CLEAR, AO_LOAD_LEN, AO_ADD, AO_SUB} acc_op_t;
    typedef enum logic [2:0] {PO_NONE, PO_ZERO, PO_MOVE1, PO_MOVE2, PO_STEP, PO_INC} ptr_op_t;
    typedef enum logic [2:0] {RO_NONE, RO_PLAIN, RO_STATUS, RO_READ, RO_SUM, RO_KEEP} res_op_t;

    typedef struct packed {
        logic     load_item;
        tour_ra_t tour_ra;
        tour_wr_t tour_wr;
        cap_t     cap;
        dist_op_t dist_op;
        acc_op_t  acc_op;
        ptr_op_t  ptr_op;
        res_op_t  res_op;
    } dp_cmd_t;

    typedef struct packed {
        logic [2:0] op;
        logic       moves_ok;
        logic       swap_more;
        logic       edge_more;
        logic       keep;
    } dp_stat_t;

endpackage

[rtl/toti_stream_if.sv]
// ----------------------------------------------------------------------------
// Stream channel
// Valid/ready channel carrying one payload per request.
// ----------------------------------------------------------------------------
interface toti_stream_if #(parameter type payload_t = logic) ();
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

[rtl/toti_ram.sv]
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module toti_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

[rtl/toti_datapath.sv]
// ----------------------------------------------------------------------------
// Two-opt datapath
// Config registers, tour and distance memories, pointers, length accumulator.
// ----------------------------------------------------------------------------
module toti_datapath
    import toti_pkg::*;
#(
    parameter int MAX_CITIES    = MAX_CITIES_DEF,
    parameter int DISTANCE_BITS = DIST_BITS_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  item_t                 item,
    output result_t               result,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  dp_cmd_t               cmd,
    output dp_stat_t              stat
);
    localparam int TPW   = $clog2(MAX_CITIES + 1);
    localparam int CW    = $clog2(MAX_CITIES);
    localparam int VW    = (TPW + 1 > 8) ? TPW + 1 : 8;
    localparam int DAW   = 2 * CW;
    localparam int DVW   = (DISTANCE_BITS > 16) ? DISTANCE_BITS : 16;
    localparam int ACC_W = (DISTANCE_BITS + 12 > 26) ? DISTANCE_BITS + 12 : 26;

    logic [7:0]  cities_reg;
    logic [6:0]  first_reg;
    logic [15:0] margin_reg;

    item_t item_reg;
    logic [TPW-1:0] i_reg, j_reg;
    logic [6:0] a_reg, b_reg, c_reg, d_reg, t_reg;
    logic signed [ACC_W-1:0] acc_reg;
    logic [LEN_W-1:0] len_reg;
    logic accepted_reg, status_reg;
    logic [6:0] city_out_reg;
    logic dok_reg;

    logic [VW-1:0] n_v, lo_v, first_v, cities_v, max_v;
    logic [VW-1:0] s1_v, e1_v, s2_v, e2_v, pos_v, i_v, j_v;
    logic          ok1, ok2, pos_ok;
    logic [TPW-1:0] pos_idx;

    logic [TPW-1:0] tour_raddr, tour_waddr;
    logic [6:0]     tour_wdata, tour_rdata;
    logic           tour_we;

    logic [6:0]     x_city, y_city;
    logic [VW-1:0]  x_v, y_v, from_v, to_v;
    logic [DAW-1:0] dist_raddr, dist_waddr;
    logic [DVW-1:0] dv_ext;
    logic [DISTANCE_BITS-1:0] dist_rdata;
    logic           dist_we, xy_ok;

    logic signed [ACC_W-1:0] dterm, old_len, margin_s;
    logic [LEN_W-1:0] sat_len;

    // config
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cities_reg <= CITIES_RST;
            first_reg  <= FIRST_RST;
            margin_reg <= MARGIN_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_CITIES: cities_reg <= cfg_data[7:0];
                CFG_FIRST:  first_reg  <= cfg_data[6:0];
                CFG_MARGIN: margin_reg <= cfg_data[15:0];
                default: ;
            endcase
        end
    end

    // effective tour size and movable range
    always_comb
    begin
        max_v    = VW'(MAX_CITIES);
        cities_v = VW'(cities_reg);
        if (cities_v < VW'(4))
            n_v = VW'(4);
        else if (cities_v > max_v)
            n_v = max_v;
        else
            n_v = cities_v;
        first_v = (first_reg == 7'd0) ? VW'(1) : VW'(first_reg);
        lo_v    = (first_v > n_v - VW'(3)) ? n_v - VW'(3) : first_v;
        s1_v = VW'(item_reg.first_start);
        e1_v = VW'(item_reg.first_end);
        s2_v = VW'(item_reg.second_start);
        e2_v = VW'(item_reg.second_end);
        ok1 = (s1_v >= lo_v) && (s1_v <= n_v - VW'(3)) &&
              (e1_v >= s1_v + VW'(1)) && (e1_v <= n_v - VW'(1));
        ok2 = (s2_v >= lo_v) && (s2_v <= n_v - VW'(3)) &&
              (e2_v >= s2_v + VW'(1)) && (e2_v <= n_v - VW'(1));
        pos_v   = VW'(item_reg.position);
        pos_ok  = pos_v <= max_v;
        pos_idx = pos_v[TPW-1:0];
        i_v = VW'(i_reg);
        j_v = VW'(j_reg);
    end

    // tour memory addressing
    always_comb
    begin
        case (cmd.tour_ra)
            TA_POS:  tour_raddr = pos_idx;
            TA_I:    tour_raddr = i_reg;
            TA_IM1:  tour_raddr = i_reg - TPW'(1);
            TA_IP1:  tour_raddr = i_reg + TPW'(1);
            TA_J:    tour_raddr = j_reg;
            TA_JP1:  tour_raddr = j_reg + TPW'(1);
            default: tour_raddr = i_reg;
        endcase
        case (cmd.tour_wr)
            TW_POS:
            begin
                tour_we = pos_ok; tour_waddr = pos_idx; tour_wdata = item_reg.city_id;
            end
            TW_I:
            begin
                tour_we = 1'b1; tour_waddr = i_reg; tour_wdata = tour_rdata;
            end
            TW_J:
            begin
                tour_we = 1'b1; tour_waddr = j_reg; tour_wdata = t_reg;
            end
            default:
            begin
                tour_we = 1'b0; tour_waddr = i_reg; tour_wdata = t_reg;
            end
        endcase
    end

    toti_ram #(.WIDTH(7), .DEPTH(MAX_CITIES + 1)) u_tour (
        .clk   (clk),
        .we    (tour_we),
        .waddr (tour_waddr),
        .wdata (tour_wdata),
        .raddr (tour_raddr),
        .rdata (tour_rdata)
    );

    // distance memory addressing; cities outside the table read as zero
    always_comb
    begin
        case (cmd.dist_op)
            DO_AC:   begin x_city = a_reg; y_city = c_reg; end
            DO_BD:   begin x_city = b_reg; y_city = d_reg; end
            DO_CD:   begin x_city = c_reg; y_city = d_reg; end
            default: begin x_city = a_reg; y_city = b_reg; end
        endcase
        x_v    = VW'(x_city);
        y_v    = VW'(y_city);
        xy_ok  = (x_v < max_v) && (y_v < max_v);
        dist_raddr = {x_v[CW-1:0], y_v[CW-1:0]};
        from_v = VW'(item_reg.city_from);
        to_v   = VW'(item_reg.city_to);
        dist_waddr = {from_v[CW-1:0], to_v[CW-1:0]};
        dist_we = (cmd.dist_op == DO_WRITE) && (from_v < max_v) && (to_v < max_v);
        dv_ext  = DVW'(item_reg.distance_value);
    end

    toti_ram #(.WIDTH(DISTANCE_BITS), .DEPTH(2 ** DAW)) u_dist (
        .clk   (clk),
        .we    (dist_we),
        .waddr (dist_waddr),
        .wdata (dv_ext[DISTANCE_BITS-1:0]),
        .raddr (dist_raddr),
        .rdata (dist_rdata)
    );

    // accumulator arithmetic
    always_comb
    begin
        dterm    = dok_reg ? ACC_W'(dist_rdata) : '0;
        old_len  = ACC_W'(len_reg);
        margin_s = ACC_W'(margin_reg);
        if (acc_reg < 0)
            sat_len = '0;
        else if (acc_reg > ACC_W'(LEN_MAX))
            sat_len = LEN_MAX;
        else
            sat_len = acc_reg[LEN_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        dok_reg <= xy_ok;
        if (cmd.load_item)
            item_reg <= item;
        case (cmd.cap)
            CP_A:     a_reg <= tour_rdata;
            CP_B:     b_reg <= tour_rdata;
            CP_C:     c_reg <= tour_rdata;
            CP_D:     d_reg <= tour_rdata;
            CP_T:     t_reg <= tour_rdata;
            CP_SHIFT: a_reg <= b_reg;
            default: ;
        endcase
        case (cmd.ptr_op)
            PO_ZERO:  begin i_reg <= '0; j_reg <= '0; end
            PO_MOVE1: begin i_reg <= s1_v[TPW-1:0]; j_reg <= e1_v[TPW-1:0]; end
            PO_MOVE2: begin i_reg <= s2_v[TPW-1:0]; j_reg <= e2_v[TPW-1:0]; end
            PO_STEP:  begin i_reg <= i_reg + TPW'(1); j_reg <= j_reg - TPW'(1); end
            PO_INC:   i_reg <= i_reg + TPW'(1);
            default: ;
        endcase
        case (cmd.acc_op)
            AO_CLEAR:    acc_reg <= '0;
            AO_LOAD_LEN: acc_reg <= old_len;
            AO_ADD:      acc_reg <= acc_reg + dterm;
            AO_SUB:      acc_reg <= acc_reg - dterm;
            default: ;
        endcase
        if (cmd.res_op != RO_NONE)
        begin
            accepted_reg <= (cmd.res_op == RO_KEEP);
            status_reg   <= (cmd.res_op == RO_STATUS);
            city_out_reg <= (cmd.res_op == RO_READ && pos_ok) ? tour_rdata : 7'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            len_reg <= '0;
        else if (cmd.res_op == RO_SUM || cmd.res_op == RO_KEEP)
            len_reg <= sat_len;
    end

    assign stat.op        = item_reg.opcode;
    assign stat.moves_ok  = ok1 && ok2;
    assign stat.swap_more = (i_v + VW'(2)) < j_v;
    assign stat.edge_more = i_v < n_v;
    assign stat.keep      = (acc_reg < old_len) || ((acc_reg - old_len) <= margin_s);

    assign result.tour_length = len_reg;
    assign result.accepted    = accepted_reg;
    assign result.city_out    = city_out_reg;
    assign result.status      = status_reg;
endmodule

[rtl/toti_controller.sv]
// ----------------------------------------------------------------------------
// Two-opt controller
// Sequences loads, position reads, length recompute, trial moves, reversal and undo.
// ----------------------------------------------------------------------------
module toti_controller
    import toti_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     items_valid,
    output logic     items_ready,
    output logic     results_valid,
    input  logic     results_ready,
    input  dp_stat_t stat,
    output dp_cmd_t  cmd
);
    typedef enum logic [4:0] {
        S_IDLE, S_DISPATCH, S_RD_WAIT,
        S_SUM_R0, S_SUM_R1, S_E1, S_E2, S_E3, S_E4, S_SUM_DONE,
        S_M1, S_M2, S_M3, S_M4, S_M5, S_M6, S_M7, S_M8, S_M9, S_M10,
        S_SW0, S_SW1, S_SW2, S_SW3, S_NEXT, S_DECIDE, S_OUT
    } state_t;

    typedef enum logic [1:0] {PH_MOVE1, PH_MOVE2, PH_UNDO2, PH_UNDO1} phase_t;

    state_t state_reg, state_next;
    phase_t phase_reg, phase_next;

    always_comb
    begin
        state_next = state_reg;
        phase_next = phase_reg;
        cmd = '{load_item: 1'b0, tour_ra: TA_I, tour_wr: TW_NONE, cap: CP_NONE,
                dist_op: DO_NONE, acc_op: AO_NONE, ptr_op: PO_NONE, res_op: RO_NONE};
        case (state_reg)
            S_IDLE:
            begin
                cmd.load_item = items_valid;
                if (items_valid)
                    state_next = S_DISPATCH;
            end
            S_DISPATCH:
            begin
                case (stat.op)
                    OP_LOAD_DIST:
                    begin
                        cmd.dist_op = DO_WRITE; cmd.res_op = RO_PLAIN; state_next = S_OUT;
                    end
                    OP_LOAD_POS:
                    begin
                        cmd.tour_wr = TW_POS; cmd.res_op = RO_PLAIN; state_next = S_OUT;
                    end
                    OP_RECOMPUTE:
                    begin
                        cmd.ptr_op = PO_ZERO; cmd.acc_op = AO_CLEAR; state_next = S_SUM_R0;
                    end
                    OP_TRIAL:
                    begin
                        if (!stat.moves_ok)
                        begin
                            cmd.res_op = RO_STATUS; state_next = S_OUT;
                        end
                        else
                        begin
                            cmd.acc_op = AO_LOAD_LEN; cmd.ptr_op = PO_MOVE1;
                            phase_next = PH_MOVE1; state_next = S_M1;
                        end
                    end
                    OP_READ_POS:
                    begin
                        cmd.tour_ra = TA_POS; state_next = S_RD_WAIT;
                    end
                    default:
                    begin
                        cmd.res_op = RO_PLAIN; state_next = S_OUT;
                    end
                endcase
            end
            S_RD_WAIT:  begin cmd.res_op = RO_READ; state_next = S_OUT; end
            // length recompute: one edge per pass through S_E1..S_E4
            S_SUM_R0:   begin cmd.tour_ra = TA_I; state_next = S_SUM_R1; end
            S_SUM_R1:   begin cmd.cap = CP_B; state_next = S_E1; end
            S_E1:       begin cmd.tour_ra = TA_IP1; cmd.cap = CP_SHIFT; state_next = S_E2; end
            S_E2:       begin cmd.cap = CP_B; state_next = S_E3; end
            S_E3:       begin cmd.dist_op = DO_AB; cmd.ptr_op = PO_INC; state_next = S_E4; end
            S_E4:
            begin
                cmd.acc_op = AO_ADD;
                state_next = stat.edge_more ? S_E1 : S_SUM_DONE;
            end
            S_SUM_DONE: begin cmd.res_op = RO_SUM; state_next = S_OUT; end
            // move: fetch the four end cities, then the edge change
            S_M1:  begin cmd.tour_ra = TA_IM1; state_next = S_M2; end
            S_M2:  begin cmd.tour_ra = TA_I; cmd.cap = CP_A; state_next = S_M3; end
            S_M3:  begin cmd.tour_ra = TA_J; cmd.cap = CP_B; state_next = S_M4; end
            S_M4:  begin cmd.tour_ra = TA_JP1; cmd.cap = CP_C; state_next = S_M5; end
            S_M5:  begin cmd.cap = CP_D; state_next = S_M6; end
            S_M6:  begin cmd.dist_op = DO_AC; state_next = S_M7; end
            S_M7:  begin cmd.dist_op = DO_BD; cmd.acc_op = AO_ADD; state_next = S_M8; end
            S_M8:  begin cmd.dist_op = DO_AB; cmd.acc_op = AO_ADD; state_next = S_M9; end
            S_M9:  begin cmd.dist_op = DO_CD; cmd.acc_op = AO_SUB; state_next = S_M10; end
            S_M10: begin cmd.acc_op = AO_SUB; state_next = S_SW0; end
            // segment reversal: one swapped pair per pass through S_SW1..S_SW3
            S_SW0: begin cmd.tour_ra = TA_I; state_next = S_SW1; end
            S_SW1: begin cmd.tour_ra = TA_J; cmd.cap = CP_T; state_next = S_SW2; end
            S_SW2: begin cmd.tour_wr = TW_I; state_next = S_SW3; end
            S_SW3:
            begin
                cmd.tour_wr = TW_J; cmd.ptr_op = PO_STEP; cmd.tour_ra = TA_IP1;
                state_next = stat.swap_more ? S_SW1 : S_NEXT;
            end
            S_NEXT:
            begin
                case (phase_reg)
                    PH_MOVE1:
                    begin
                        cmd.ptr_op = PO_MOVE2; phase_next = PH_MOVE2; state_next = S_M1;
                    end
                    PH_MOVE2: state_next = S_DECIDE;
                    PH_UNDO2:
                    begin
                        cmd.ptr_op = PO_MOVE1; phase_next = PH_UNDO1; state_next = S_SW0;
                    end
                    default:
                    begin
                        cmd.res_op = RO_PLAIN; state_next = S_OUT;
                    end
                endcase
            end
            S_DECIDE:
            begin
                if (stat.keep)
                begin
                    cmd.res_op = RO_KEEP; state_next = S_OUT;
                end
                else
                begin
                    cmd.ptr_op = PO_MOVE2; phase_next = PH_UNDO2; state_next = S_SW0;
                end
            end
            S_OUT:
            begin
                if (results_ready)
                    state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            phase_reg <= PH_MOVE1;
        end
        else
        begin
            state_reg <= state_next;
            phase_reg <= phase_next;
        end
    end

    assign items_ready   = (state_reg == S_IDLE);
    assign results_valid = (state_reg == S_OUT);

    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(items_ready && results_valid))
        else $error("input taken while a result is pending");

    a_idle_no_write: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE) |-> (cmd.tour_wr == TW_NONE && cmd.dist_op == DO_NONE))
        else $error("memory write while idle");

    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.res_op != RO_NONE) |=> results_valid)
        else $error("result not presented after update");

    a_load_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_item |=> (state_reg == S_DISPATCH))
        else $error("accepted item not dispatched");
endmodule

[rtl/two_opt_tour_improver_unit.sv]
// ----------------------------------------------------------------------------
// Two-opt tour improver
// Distance table and closed tour with 2-opt trial moves and undo.
// ----------------------------------------------------------------------------
// Usage:
//   items   - one request per item: load distance, load tour position,
//             recompute length, trial of two 2-opt moves, read position.
//   results - exactly one result per item, in order.
//   cfg_*   - register write port (tour size, lowest movable position,
//             accept margin); write only while the block is idle.
// Throughput: one item at a time. A recompute walks every edge of the
//   tour through the tour and distance memories and sums the distances.
//   A trial runs each move in turn: it fetches the four end cities,
//   applies the edge change and reverses the segment; a rejected trial
//   then reverses both segments again as the undo. The tour memory has
//   a single read port.
// Reset: registers return to 127 / 1 / 100 and the length to zero; the
//   memories are not cleared and must be loaded before use.
// Stall: a result is held on results until taken; no new item is taken
//   meanwhile.
// ----------------------------------------------------------------------------
module two_opt_tour_improver_unit
    import toti_pkg::*;
#(
    parameter int MAX_CITIES    = MAX_CITIES_DEF,
    parameter int DISTANCE_BITS = DIST_BITS_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    toti_stream_if.sink           items,
    toti_stream_if.source         results,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);
    dp_cmd_t  cmd;
    dp_stat_t stat;
    result_t  result;

    // sequencing
    toti_controller u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .items_valid   (items.valid),
        .items_ready   (items.ready),
        .results_valid (results.valid),
        .results_ready (results.ready),
        .stat          (stat),
        .cmd           (cmd)
    );

    // storage and arithmetic
    toti_datapath #(
        .MAX_CITIES    (MAX_CITIES),
        .DISTANCE_BITS (DISTANCE_BITS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .item      (items.payload),
        .result    (result),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .stat      (stat)
    );

    assign results.payload = result;
endmodule
